FILE: design/fha_pkg.sv
// Shared types and constants for the IPv4 flow and host accounting block.
package fha_pkg;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  // Ethernet header plus minimal IPv4 header
  localparam logic [16:0] MIN_IPV4_FRAME = 17'd34;
  // Ethernet header plus transport header, IPv4 header length added on top
  localparam logic [16:0] TCP_FIT_BASE   = 17'd34;
  localparam logic [16:0] UDP_FIT_BASE   = 17'd22;

  localparam logic [39:0] BW_THRESHOLD_RESET    = 40'd10485760;
  localparam logic [10:0] SPIKE_THRESHOLD_RESET = 11'd500;

  localparam logic [10:0] LIVE_FLOWS_MAX = 11'd2047;

  localparam logic RECORD_ALERT   = 1'b0;
  localparam logic RECORD_SUMMARY = 1'b1;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // register select taken from paddr[3]
  localparam logic REG_BANDWIDTH = 1'b0;
  localparam logic REG_SPIKE     = 1'b1;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
  } flow_key_t;

  localparam int KEY_W = $bits(flow_key_t);

endpackage

FILE: design/ipv4_flow_host_accounting.sv
// Top level: sequencer, flow and host tables, config registers and output register.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | in_valid/in_stall  | req_type .. raw_dest_port
//   output   | out_valid/out_stall| record_kind .. last
//   config   | APB psel/penable   | paddr[3:0], pwdata/prdata 64 bits
//
// A packet beat holds in_stall while it scans the flow table (read, compare
// per valid flow), looks up its source and then its destination host (read,
// compare, byte and packet update) and adds to the totals; a dropped frame
// costs none. A tick beat reads, sums and compares each valid host, sends
// alerts and then the summary, and waits while out_stall holds a record.
// Reset empties both tables at once through their fill counts and restores
// the thresholds.
module ipv4_flow_host_accounting
  import fha_pkg::*;
#(
  parameter int FLOW_ENTRIES = 1024,
  parameter int HOST_ENTRIES = 1024,
  parameter int MAX_ALERTS   = 63
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] cap_len,
  input  logic [15:0] wire_len,
  input  logic [15:0] eth_type,
  input  logic [3:0]  ip_header_words,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] raw_source_port,
  input  logic [15:0] raw_dest_port,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        record_kind,
  output logic [31:0] host_address,
  output logic [63:0] sent_bytes,
  output logic [63:0] bytes_received,
  output logic [63:0] packets_sent,
  output logic [63:0] packets_received,
  output logic [63:0] window_bytes,
  output logic [63:0] window_packets,
  output logic [10:0] live_flows,
  output logic        spike_alarm,
  output logic        overflow,
  output logic        last,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int FIW = $clog2(FLOW_ENTRIES);
  localparam int FCW = $clog2(FLOW_ENTRIES + 1);
  localparam int HIW = $clog2(HOST_ENTRIES);
  localparam int HCW = $clog2(HOST_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_ALERTS + 1);

  localparam logic [FCW-1:0] FLOW_FULL  = FCW'(FLOW_ENTRIES);
  localparam logic [HCW-1:0] HOST_FULL  = HCW'(HOST_ENTRIES);
  localparam logic [AW-1:0]  ALERTS_MAX = AW'(MAX_ALERTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;
  localparam logic [3:0] S_FCMP = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HCMP = 4'd4;
  localparam logic [3:0] S_HUPB = 4'd5;
  localparam logic [3:0] S_HUPP = 4'd6;
  localparam logic [3:0] S_TOTB = 4'd7;
  localparam logic [3:0] S_TOTP = 4'd8;
  localparam logic [3:0] S_WRD  = 4'd9;
  localparam logic [3:0] S_WADD = 4'd10;
  localparam logic [3:0] S_WCMP = 4'd11;
  localparam logic [3:0] S_WOUT = 4'd12;
  localparam logic [3:0] S_SUM  = 4'd13;

  logic [3:0]     state;
  logic [39:0]    bw_thr;
  logic [10:0]    spike_thr;
  logic [FCW-1:0] flow_fill;
  logic [HCW-1:0] host_fill;
  logic [FCW-1:0] fidx;
  logic [HCW-1:0] hidx;
  logic [AW-1:0]  alerts;
  logic           trunc;
  logic           ovf;
  logic           dir;
  logic [63:0]    tot_b;
  logic [63:0]    tot_p;
  logic [63:0]    sum_r;
  flow_key_t      key_r;
  logic [15:0]    wire_r;

  // table storage
  logic [KEY_W-1:0] flow_mem [FLOW_ENTRIES];
  logic [KEY_W-1:0] flow_rd;
  logic [31:0]      haddr_mem [HOST_ENTRIES];
  logic [63:0]      txb_mem [HOST_ENTRIES];
  logic [63:0]      rxb_mem [HOST_ENTRIES];
  logic [63:0]      txp_mem [HOST_ENTRIES];
  logic [63:0]      rxp_mem [HOST_ENTRIES];
  logic [31:0]      haddr_rd;
  logic [63:0]      txb_rd;
  logic [63:0]      rxb_rd;
  logic [63:0]      txp_rd;
  logic [63:0]      rxp_rd;

  logic        in_acc;
  logic        out_free;
  logic        cfg_wr;
  logic [16:0] ihl17;
  logic        hdr_ok;
  logic        use_ports;
  logic [31:0] tgt;
  logic        f_re;
  logic        f_we;
  logic        h_re;
  logic        h_ins;
  logic        txb_we;
  logic        rxb_we;
  logic        txp_we;
  logic        rxp_we;
  logic [63:0] txb_wd;
  logic [63:0] rxb_wd;
  logic [63:0] txp_wd;
  logic [63:0] rxp_wd;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_sum;
  logic        alu_gt;
  logic [16:0] fc17;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    if (paddr[3] == REG_SPIKE) begin
      prdata = {53'b0, spike_thr};
    end else begin
      prdata = {24'b0, bw_thr};
    end
  end

  // header checks on the incoming beat
  assign ihl17  = {11'b0, ip_header_words, 2'b0};
  assign hdr_ok = ({1'b0, cap_len} >= MIN_IPV4_FRAME) && (eth_type == ETH_TYPE_IPV4);
  assign use_ports =
    ((ip_protocol == PROTO_TCP) && ({1'b0, cap_len} >= TCP_FIT_BASE + ihl17)) ||
    ((ip_protocol == PROTO_UDP) && ({1'b0, cap_len} >= UDP_FIT_BASE + ihl17));

  assign tgt = dir ? key_r.dst : key_r.src;

  // memory controls
  assign f_re  = (state == S_FRD) && (fidx != flow_fill);
  assign f_we  = (state == S_FRD) && (fidx == flow_fill) && (flow_fill != FLOW_FULL);
  assign h_re  = ((state == S_HRD) || (state == S_WRD)) && (hidx != host_fill);
  assign h_ins = (state == S_HRD) && (hidx == host_fill) && (host_fill != HOST_FULL);

  assign txb_we = h_ins || ((state == S_HUPB) && !dir);
  assign rxb_we = h_ins || ((state == S_HUPB) && dir);
  assign txp_we = h_ins || ((state == S_HUPP) && !dir);
  assign rxp_we = h_ins || ((state == S_HUPP) && dir);

  always_comb begin
    if (h_ins) begin
      txb_wd = dir ? 64'd0 : {48'b0, wire_r};
      rxb_wd = dir ? {48'b0, wire_r} : 64'd0;
      txp_wd = dir ? 64'd0 : 64'd1;
      rxp_wd = dir ? 64'd1 : 64'd0;
    end else begin
      txb_wd = alu_sum;
      rxb_wd = alu_sum;
      txp_wd = alu_sum;
      rxp_wd = alu_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      flow_mem[fidx[FIW-1:0]] <= key_r;
    end
    if (f_re) begin
      flow_rd <= flow_mem[fidx[FIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (h_ins) begin
      haddr_mem[hidx[HIW-1:0]] <= tgt;
    end
    if (txb_we) begin
      txb_mem[hidx[HIW-1:0]] <= txb_wd;
    end
    if (rxb_we) begin
      rxb_mem[hidx[HIW-1:0]] <= rxb_wd;
    end
    if (txp_we) begin
      txp_mem[hidx[HIW-1:0]] <= txp_wd;
    end
    if (rxp_we) begin
      rxp_mem[hidx[HIW-1:0]] <= rxp_wd;
    end
    if (h_re) begin
      haddr_rd <= haddr_mem[hidx[HIW-1:0]];
      txb_rd   <= txb_mem[hidx[HIW-1:0]];
      rxb_rd   <= rxb_mem[hidx[HIW-1:0]];
      txp_rd   <= txp_mem[hidx[HIW-1:0]];
      rxp_rd   <= rxp_mem[hidx[HIW-1:0]];
    end
  end

  // operand select for the shared unit
  always_comb begin
    unique case (state)
      S_HUPB: begin
        alu_a = dir ? rxb_rd : txb_rd;
        alu_b = {48'b0, wire_r};
      end
      S_HUPP: begin
        alu_a = dir ? rxp_rd : txp_rd;
        alu_b = 64'd1;
      end
      S_TOTB: begin
        alu_a = tot_b;
        alu_b = {48'b0, wire_r};
      end
      S_TOTP: begin
        alu_a = tot_p;
        alu_b = 64'd1;
      end
      S_WADD: begin
        alu_a = txb_rd;
        alu_b = rxb_rd;
      end
      S_WCMP: begin
        alu_a = sum_r;
        alu_b = {24'b0, bw_thr};
      end
      default: begin
        alu_a = 64'd0;
        alu_b = 64'd0;
      end
    endcase
  end

  fha_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  assign fc17 = 17'(flow_fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bw_thr    <= BW_THRESHOLD_RESET;
      spike_thr <= SPIKE_THRESHOLD_RESET;
      flow_fill <= '0;
      host_fill <= '0;
      tot_b     <= 64'd0;
      tot_p     <= 64'd0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      fidx      <= '0;
      hidx      <= '0;
      alerts    <= '0;
      trunc     <= 1'b0;
      dir       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[3] == REG_SPIKE) begin
          spike_thr <= pwdata[10:0];
        end else begin
          bw_thr <= pwdata[39:0];
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            key_r.src   <= source_address;
            key_r.dst   <= dest_address;
            key_r.proto <= ip_protocol;
            key_r.ports <= use_ports ? {raw_source_port, raw_dest_port} : 32'd0;
            wire_r      <= wire_len;
            fidx        <= '0;
            hidx        <= '0;
            dir         <= 1'b0;
            alerts      <= '0;
            trunc       <= 1'b0;
            if (req_type == REQ_TICK) begin
              state <= S_WRD;
            end else if (hdr_ok) begin
              state <= S_FRD;
            end
          end
        end
        S_FRD: begin
          if (fidx == flow_fill) begin
            if (flow_fill == FLOW_FULL) begin
              ovf <= 1'b1;
            end else begin
              flow_fill <= flow_fill + 1'b1;
            end
            state <= S_HRD;
          end else begin
            state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (flow_rd == key_r) begin
            state <= S_HRD;
          end else begin
            fidx  <= fidx + 1'b1;
            state <= S_FRD;
          end
        end
        S_HRD: begin
          if (hidx == host_fill) begin
            // new host written in place with its first update, or dropped
            if (host_fill == HOST_FULL) begin
              ovf <= 1'b1;
            end else begin
              host_fill <= host_fill + 1'b1;
            end
            if (dir) begin
              state <= S_TOTB;
            end else begin
              dir   <= 1'b1;
              hidx  <= '0;
              state <= S_HRD;
            end
          end else begin
            state <= S_HCMP;
          end
        end
        S_HCMP: begin
          if (haddr_rd == tgt) begin
            state <= S_HUPB;
          end else begin
            hidx  <= hidx + 1'b1;
            state <= S_HRD;
          end
        end
        S_HUPB: begin
          state <= S_HUPP;
        end
        S_HUPP: begin
          if (dir) begin
            state <= S_TOTB;
          end else begin
            dir   <= 1'b1;
            hidx  <= '0;
            state <= S_HRD;
          end
        end
        S_TOTB: begin
          tot_b <= alu_sum;
          state <= S_TOTP;
        end
        S_TOTP: begin
          tot_p <= alu_sum;
          state <= S_IDLE;
        end
        S_WRD: begin
          if (hidx == host_fill) begin
            state <= S_SUM;
          end else begin
            state <= S_WADD;
          end
        end
        S_WADD: begin
          sum_r <= alu_sum;
          state <= S_WCMP;
        end
        S_WCMP: begin
          if (alu_gt && (alerts != ALERTS_MAX)) begin
            state <= S_WOUT;
          end else begin
            if (alu_gt) begin
              trunc <= 1'b1;
            end
            hidx  <= hidx + 1'b1;
            state <= S_WRD;
          end
        end
        S_WOUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            record_kind      <= RECORD_ALERT;
            host_address     <= haddr_rd;
            sent_bytes       <= txb_rd;
            bytes_received   <= rxb_rd;
            packets_sent     <= txp_rd;
            packets_received <= rxp_rd;
            window_bytes     <= 64'd0;
            window_packets   <= 64'd0;
            live_flows       <= 11'd0;
            spike_alarm      <= 1'b0;
            overflow         <= 1'b0;
            last             <= 1'b0;
            alerts           <= alerts + 1'b1;
            hidx             <= hidx + 1'b1;
            state            <= S_WRD;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            record_kind      <= RECORD_SUMMARY;
            host_address     <= 32'd0;
            sent_bytes       <= 64'd0;
            bytes_received   <= 64'd0;
            packets_sent     <= 64'd0;
            packets_received <= 64'd0;
            window_bytes     <= tot_b;
            window_packets   <= tot_p;
            live_flows       <= (fc17 > {6'b0, LIVE_FLOWS_MAX}) ? LIVE_FLOWS_MAX
                                                                : fc17[10:0];
            spike_alarm      <= fc17 > {6'b0, spike_thr};
            overflow         <= ovf || trunc;
            last             <= 1'b1;
            // drop the window
            flow_fill        <= '0;
            host_fill        <= '0;
            tot_b            <= 64'd0;
            tot_p            <= 64'd0;
            ovf              <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/fha_alu.sv
// Shared 64-bit adder and magnitude compare used by the sequencer.
module fha_alu
  import fha_pkg::*;
(
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] sum,
  output logic        gt
);

  assign sum = a + b;
  assign gt  = a > b;

endmodule
